@@ hdl/pavg_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pavg_pkg
// Shared types and constants of the pressure average estimator.
// ============================================================================
package pavg_pkg;

    localparam int FX_FRAC      = 11;
    localparam int ONE_W        = FX_FRAC + 1;
    localparam int ONE_FX       = 1 << FX_FRAC;
    localparam int HALF_FX      = 1 << (FX_FRAC - 1);
    localparam int DECAY_Q11    = 1677;
    localparam int DECAY_FX     = (DECAY_Q11 * ONE_FX + 1024) >> 11;
    localparam int GAIN_FX      = ONE_FX - DECAY_FX;
    localparam int MISSED_CAP   = 255;
    localparam int CAP_W        = $clog2(MISSED_CAP + 1);
    localparam int PCT_SCALE    = 100;
    localparam int PCT_W        = 7;
    localparam int AVG_W        = 18;
    localparam int HUND_W       = 14;
    localparam int TIME_W       = 64;
    localparam int PER_W        = 32;
    localparam int NUM_W        = TIME_W + PCT_W;
    localparam int DCNT_W       = $clog2(NUM_W);
    localparam logic [PER_W-1:0] PERIOD_RESET = 32'd2004000000;

    // register index decoded from paddr[2]
    localparam logic REG_PERIOD = 1'b0;

    typedef struct packed {
        logic [TIME_W-1:0] now_ns;
        logic [TIME_W-1:0] next_update;
        logic [TIME_W-1:0] last_update;
        logic [AVG_W-1:0]  avg_in;
        logic [TIME_W-1:0] total_stall;
        logic [TIME_W-1:0] total_at_last;
    } in_item_t;

    typedef struct packed {
        logic [AVG_W-1:0]  avg_out;
        logic [HUND_W-1:0] avg_hundredths;
        logic              refreshed;
    } res_item_t;

    // item after classification by the front end
    typedef struct packed {
        logic              due;
        logic [TIME_W-1:0] since_due;
        logic [TIME_W-1:0] base_elapsed;
        logic [TIME_W-1:0] sample_raw;
        logic [AVG_W-1:0]  avg;
    } cls_item_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [TIME_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [NUM_W-1:0]  quo;
        logic [TIME_W-1:0] rem;
    } div_rsp_t;

endpackage

@@ hdl/pavg_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pavg_front
// Accept items, classify them and hold them in a two-entry queue.
// ============================================================================
module pavg_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pavg_pkg::in_item_t   item,
    input  logic                 pop,
    output logic                 empty,
    output pavg_pkg::cls_item_t  cls
);
    pavg_pkg::cls_item_t cls_in;
    pavg_pkg::cls_item_t q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    always_comb
    begin
        cls_in.due          = (item.now_ns >= item.next_update);
        cls_in.since_due    = item.now_ns - item.next_update;
        cls_in.base_elapsed = item.next_update - item.last_update;
        cls_in.sample_raw   = item.total_stall - item.total_at_last;
        cls_in.avg          = item.avg_in;
    end

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign cls     = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= cls_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

@@ hdl/pavg_div.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pavg_div
// Serial restoring divider, one quotient bit per cycle.
// ============================================================================
module pavg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pavg_pkg::div_req_t  req,
    output pavg_pkg::div_rsp_t  rsp
);
    localparam int NW = pavg_pkg::NUM_W;
    localparam int TW = pavg_pkg::TIME_W;
    localparam int CW = pavg_pkg::DCNT_W;

    logic [NW-1:0] num_reg, quo_reg;
    logic [TW-1:0] den_reg, rem_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg, done_reg;
    logic [TW:0]   rs, diff;
    logic          ge;

    always_comb
    begin
        rs   = {rem_reg, num_reg[NW-1]};
        ge   = (rs >= {1'b0, den_reg});
        diff = rs - {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            rem_reg <= ge ? diff[TW-1:0] : rs[TW-1:0];
            quo_reg <= {quo_reg[NW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_comb
    begin
        rsp.busy = busy_reg;
        rsp.done = done_reg;
        rsp.quo  = quo_reg;
        rsp.rem  = rem_reg;
    end
endmodule

@@ hdl/pavg_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pavg_back
// Sequencer: missed periods, decay power, stall percentage, final fold and hundredths.
// ============================================================================
module pavg_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pavg_pkg::PER_W-1:0] period,
    input  logic                       item_empty,
    input  pavg_pkg::cls_item_t        cls,
    output logic                       item_pop,
    input  logic                       res_full,
    output logic                       res_push,
    output pavg_pkg::res_item_t        res
);
    localparam int TW = pavg_pkg::TIME_W;
    localparam int NW = pavg_pkg::NUM_W;
    localparam int FB = pavg_pkg::FX_FRAC;
    localparam int OW = pavg_pkg::ONE_W;
    localparam int AW = pavg_pkg::AVG_W;
    localparam int KW = pavg_pkg::CAP_W;
    localparam int PW = pavg_pkg::PCT_W;
    localparam int VW = AW + OW + 2;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DIV1   = 10'b0000000010,
        S_CHK    = 10'b0000000100,
        S_POW    = 10'b0000001000,
        S_DECAY  = 10'b0000010000,
        S_PSTART = 10'b0000100000,
        S_DIV2   = 10'b0001000000,
        S_FOLD   = 10'b0010000000,
        S_HUND   = 10'b0100000000,
        S_EMIT   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    pavg_pkg::div_req_t div_req;
    pavg_pkg::div_rsp_t div_rsp;

    logic [TW-1:0] base_el_reg, sample_reg, elapsed_reg;
    logic [AW-1:0] avg_reg;
    logic [KW-1:0] n_reg;
    logic          missed_nz_reg;
    logic [OW-1:0] acc_reg, base_reg;
    logic [NW-1:0] num_reg;
    logic          fresh_reg;
    logic [pavg_pkg::HUND_W-1:0] hund_reg;

    logic [TW-1:0] sample_clamp;
    logic [NW-1:0] s_ext;
    logic [2*OW:0] acc_prod, base_prod;
    logic [VW-1:0] dec_v, fold_v;
    logic [AW+OW-1:0] dec_mul;
    logic [PW+FB-1:0] active;
    logic [pavg_pkg::HUND_W-1:0] hund_int;
    logic [FB+PW-1:0] hund_frac;

    pavg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        sample_clamp = (sample_reg > elapsed_reg) ? elapsed_reg : sample_reg;
        s_ext        = NW'(sample_clamp);
        acc_prod     = (2*OW+1)'(acc_reg * base_reg) + (2*OW+1)'(pavg_pkg::HALF_FX);
        base_prod    = (2*OW+1)'(base_reg * base_reg) + (2*OW+1)'(pavg_pkg::HALF_FX);
        dec_mul      = (AW+OW)'(avg_reg * acc_reg);
        dec_v        = VW'(dec_mul) + ((avg_reg == '0) ? VW'(pavg_pkg::ONE_FX - 1) : '0);
        active       = {div_rsp.quo[PW-1:0], {FB{1'b0}}};
        fold_v       = VW'(avg_reg * OW'(pavg_pkg::DECAY_FX))
                     + VW'(active * OW'(pavg_pkg::GAIN_FX))
                     + ((AW'(active) >= avg_reg) ? VW'(pavg_pkg::ONE_FX - 1) : '0);
        hund_int     = pavg_pkg::HUND_W'(avg_reg[AW-1:FB] * PW'(pavg_pkg::PCT_SCALE));
        hund_frac    = (FB+PW)'(avg_reg[FB-1:0] * PW'(pavg_pkg::PCT_SCALE));
    end

    // hand one item at a time to the datapath
    always_comb
    begin
        state_next    = state_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = {{(NW-TW){1'b0}}, cls.since_due};
        div_req.den   = TW'(period);
        case (state_reg)
            S_IDLE:
            begin
                if (!item_empty)
                begin
                    item_pop = 1'b1;
                    if (cls.due)
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_DIV1;
                    end
                    else
                    begin
                        state_next = S_HUND;
                    end
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if (elapsed_reg == '0)
                begin
                    state_next = S_HUND;
                end
                else if (missed_nz_reg)
                begin
                    state_next = S_POW;
                end
                else
                begin
                    state_next = S_PSTART;
                end
            end
            S_POW:
            begin
                if (n_reg == '0)
                begin
                    state_next = S_DECAY;
                end
            end
            S_DECAY:
            begin
                state_next = S_PSTART;
            end
            S_PSTART:
            begin
                div_req.start = 1'b1;
                div_req.num   = num_reg;
                div_req.den   = elapsed_reg;
                state_next    = S_DIV2;
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FOLD;
                end
            end
            S_FOLD:
            begin
                state_next = S_HUND;
            end
            S_HUND:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                base_el_reg <= cls.base_elapsed;
                sample_reg  <= cls.sample_raw;
                avg_reg     <= cls.avg;
                fresh_reg   <= 1'b0;
            end
            S_DIV1:
            begin
                // elapsed = due - last + (now - due) mod period
                elapsed_reg   <= base_el_reg + div_rsp.rem;
                missed_nz_reg <= (div_rsp.quo[TW-1:0] != '0);
                n_reg         <= (div_rsp.quo[TW-1:KW] != '0) ? KW'(pavg_pkg::MISSED_CAP)
                                                             : div_rsp.quo[KW-1:0];
            end
            S_CHK:
            begin
                num_reg  <= (s_ext << 6) + (s_ext << 5) + (s_ext << 2);
                acc_reg  <= OW'(pavg_pkg::ONE_FX);
                base_reg <= OW'(pavg_pkg::DECAY_FX);
            end
            S_POW:
            begin
                if (n_reg != '0)
                begin
                    if (n_reg[0])
                    begin
                        acc_reg <= acc_prod[FB+OW-1:FB];
                    end
                    base_reg <= base_prod[FB+OW-1:FB];
                    n_reg    <= n_reg >> 1;
                end
            end
            S_DECAY:
            begin
                avg_reg <= dec_v[FB+AW-1:FB];
            end
            S_FOLD:
            begin
                avg_reg   <= fold_v[FB+AW-1:FB];
                fresh_reg <= 1'b1;
            end
            S_HUND:
            begin
                hund_reg <= hund_int + pavg_pkg::HUND_W'(hund_frac[FB+PW-1:FB]);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        res.avg_out        = avg_reg;
        res.avg_hundredths = hund_reg;
        res.refreshed      = fresh_reg;
    end
endmodule

@@ hdl/pavg_outq.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pavg_outq
// Two-entry result queue between the sequencer and the result side.
// ============================================================================
module pavg_outq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  pavg_pkg::res_item_t  din,
    input  logic                 pop,
    output logic                 empty,
    output pavg_pkg::res_item_t  dout
);
    pavg_pkg::res_item_t q_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = q_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end
endmodule

@@ hdl/pressure_avg10_estimator_unit.sv @@
`timescale 1ns / 1ps
// ============================================================================
// pressure_avg10_estimator_unit
// Ten-second exponential pressure average, 11 fraction bits.
// Steps: an item not yet due goes straight to hundredths; otherwise
//   two 71-step serial divisions, up to 8 powering steps, fold, hundredths.
// Throughput: one item at a time in the sequencer, so the serial divider
//   sets the rate; two input items and two results may queue.
// Reset: rst_n clears the queues and sequencer at once; period_ns = 2004000000.
// ============================================================================
module pressure_avg10_estimator_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    // input item side
    input  logic                 push,
    output logic                 full,
    input  pavg_pkg::in_item_t   item,
    // result side
    output logic                 empty,
    input  logic                 pop,
    output pavg_pkg::res_item_t  result,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    logic [pavg_pkg::PER_W-1:0] period_reg;
    logic [pavg_pkg::PER_W-1:0] period_eff;
    logic                       cfg_wr;

    logic                 item_empty, item_pop;
    pavg_pkg::cls_item_t  cls;
    logic                 res_full, res_push;
    pavg_pkg::res_item_t  res;

    // Configuration: single register, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == pavg_pkg::REG_PERIOD) ? period_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= pavg_pkg::PERIOD_RESET;
        end
        else if (cfg_wr && paddr[2] == pavg_pkg::REG_PERIOD)
        begin
            period_reg <= pwdata;
        end
    end

    // Treat a zero period as one so the divider never sees a zero divisor.
    assign period_eff = (period_reg == '0) ? pavg_pkg::PER_W'(1) : period_reg;

    // Front: take items, work out the time and stall deltas, queue them.
    pavg_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .item  (item),
        .pop   (item_pop),
        .empty (item_empty),
        .cls   (cls)
    );

    // Back: missed periods, decay, stall percentage, fold and hundredths.
    pavg_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .period     (period_eff),
        .item_empty (item_empty),
        .cls        (cls),
        .item_pop   (item_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res        (res)
    );

    // Result queue: lets the sequencer finish while the consumer stalls.
    pavg_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res),
        .pop   (pop),
        .empty (empty),
        .dout  (result)
    );

    // The sequencer only emits into a queue with room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    // The sequencer only takes an item that is there.
    a_pop_avail: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |-> !item_empty)
        else $error("item taken from an empty queue");

    // An item popped means a result is pushed before the next pop.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_pop |=> !item_pop)
        else $error("two items taken back to back");
endmodule
